[src/mbhp_pkg.sv]
package mbhp_pkg;

    // Field and arithmetic widths
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_BITS      = 9;
    localparam int COEFF_BITS   = 32;
    localparam int FRAC_BITS    = 28;
    localparam int STATE_BITS   = 48;
    localparam int PROD_BITS    = COEFF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS     = STATE_BITS + 2;
    localparam int ROUND_BITS   = ACC_BITS - FRAC_BITS;
    localparam int CFG_IDX_BITS = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A2 = 3'd4;

    // b0 resets to 1.0 in Q3.28
    localparam logic signed [COEFF_BITS-1:0] B0_RESET = 32'sd268435456;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(2 ** (FRAC_BITS - 1));

    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic signed [STATE_BITS-1:0] ST_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] ST_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    // Input word
    typedef struct packed {
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          is_electrode;
        logic                          last_in_block;
    } sample_t;

    // Output word
    typedef struct packed {
        logic [CH_BITS-1:0]            channel_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
        logic                          last_out;
    } result_t;

    // Per-channel delay pair as stored in the state RAM
    typedef struct packed {
        logic signed [STATE_BITS-1:0] delay_one;
        logic signed [STATE_BITS-1:0] delay_two;
    } state_pair_t;

    // Clamp a widened sum back to the 48-bit state range
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-STATE_BITS:0] top;
        logic signed [STATE_BITS-1:0] res;
        begin
            top = v[ACC_BITS-1:STATE_BITS-1];
            if ((&top) || !(|top))
            begin
                res = v[STATE_BITS-1:0];
            end
            else if (v[ACC_BITS-1])
            begin
                res = ST_MIN;
            end
            else
            begin
                res = ST_MAX;
            end
            return res;
        end
    endfunction

endpackage

[src/multichannel_biquad_highpass.sv]
// Multichannel biquad high-pass, transposed direct form II, shared Q3.28 coefficients.
// Input channel: sample_valid/sample_ready carry one sample word (channel, sample,
// electrode flag, block-end mark). Output channel: result_valid/result_ready carry
// one result word per input word, in input order.
// Coefficients are written on cfg_write/cfg_index/cfg_data; the user must do so only
// while no word is in flight, which the block does not enforce. A word passes stages
// one to four, then the output register, before its result is presented. Throughput:
// one word per cycle unless stalled. The per-channel delay pair is read at acceptance
// and written back when the word leaves stage four; any word whose channel matches an
// electrode word still in stages one to four is held off until that write is done.
// Reset: coefficients return to b0 = 1.0, others 0; the state RAM is then cleared one
// channel per cycle, all NUM_CHANNELS entries, with sample_ready low meanwhile. Stall:
// each stage moves when the next one is free, so bubbles close up while result_ready
// is low; sample_ready drops once all five stages hold words or on a channel hazard.
module multichannel_biquad_highpass
    import mbhp_pkg::*;
#(
    parameter int NUM_CHANNELS = 512
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [COEFF_BITS-1:0]         cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  sample_t                       sample_data,
    output logic                          result_valid,
    input  logic                          result_ready,
    output result_t                       result_data
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CMP_W  = ($clog2(NUM_CHANNELS + 1) > CH_BITS) ?
                            $clog2(NUM_CHANNELS + 1) : CH_BITS;

    // Coefficient registers
    logic signed [COEFF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= B0_RESET;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_B0:  b0_reg <= cfg_data;
                CFG_B1:  b1_reg <= cfg_data;
                CFG_B2:  b2_reg <= cfg_data;
                CFG_A1:  a1_reg <= cfg_data;
                CFG_A2:  a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline valid bits and per-stage control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic f1_reg, f2_reg, f3_reg, f4_reg;
    logic [CH_BITS-1:0] ch1_reg, ch2_reg, ch3_reg, ch4_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg;
    logic free1, free2, free3, free4, free5;
    logic hazard, accept, ram_busy, ch_in_range, filt_in;
    logic [CMP_W-1:0] ch_wide;

    // Stage payload
    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg;
    logic signed [PROD_BITS-1:0]   pb0_1_reg, pb1_1_reg, pb2_1_reg;
    logic signed [PROD_BITS-1:0]   pb1_2_reg, pb2_2_reg, pb1_3_reg, pb2_3_reg;
    logic signed [PROD_BITS-1:0]   pb1_4_reg, pb2_4_reg, pa1_4_reg, pa2_4_reg;
    logic signed [STATE_BITS-1:0]  z2_2_reg, z2_3_reg, z2_4_reg;
    logic signed [ACC_BITS-1:0]    acc2_reg;
    logic signed [SAMPLE_BITS-1:0] y3_reg, y4_reg;
    logic                          sat3_reg, sat4_reg;
    result_t                       result_reg;

    // Combinational stage terms
    logic signed [PROD_BITS-1:0]   pb0_next, pb1_next, pb2_next, pa1_next, pa2_next;
    logic signed [ACC_BITS-1:0]    acc_next, z1_sum, z2_sum;
    logic [ROUND_BITS-1:0]         rnd;
    logic [ROUND_BITS-SAMPLE_BITS:0] rnd_top;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          sat_next;

    state_pair_t       rd_pair, wr_pair;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    // Stage advance: a stage loads when it is empty or its word moves on
    assign free5 = !v5_reg || result_ready;
    assign free4 = !v4_reg || free5;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;

    // Channel range check and read-after-write interlock
    assign ch_wide     = CMP_W'(sample_data.channel);
    assign ch_in_range = ch_wide < CMP_W'(NUM_CHANNELS);
    assign filt_in     = sample_data.is_electrode && ch_in_range;
    assign hazard = (v1_reg && f1_reg && ch1_reg == sample_data.channel) ||
                    (v2_reg && f2_reg && ch2_reg == sample_data.channel) ||
                    (v3_reg && f3_reg && ch3_reg == sample_data.channel) ||
                    (v4_reg && f4_reg && ch4_reg == sample_data.channel);

    assign sample_ready = free1 && !hazard && !ram_busy;
    assign accept       = sample_valid && sample_ready;

    // State RAM: read at acceptance, written as a word leaves stage four
    assign rd_addr = ADDR_W'(sample_data.channel);
    assign wr_addr = ADDR_W'(ch4_reg);
    assign wr_en   = v4_reg && f4_reg && free5;

    mbhp_state_ram #(
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (free1),
        .rd_addr (rd_addr),
        .rd_data (rd_pair),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_pair),
        .busy    (ram_busy)
    );

    // Stage 1 inputs: feedforward products
    assign pb0_next = b0_reg * sample_data.sample_in;
    assign pb1_next = b1_reg * sample_data.sample_in;
    assign pb2_next = b2_reg * sample_data.sample_in;

    // Stage 2 inputs: accumulator with rounding offset
    assign acc_next = ACC_BITS'(pb0_1_reg) + ACC_BITS'(rd_pair.delay_one) + ROUND_HALF;

    // Stage 3 inputs: round and clip to the sample range
    assign rnd     = acc2_reg[ACC_BITS-1:FRAC_BITS];
    assign rnd_top = rnd[ROUND_BITS-1:SAMPLE_BITS-1];

    always_comb
    begin
        if (!f2_reg)
        begin
            y_next   = x2_reg;
            sat_next = 1'b0;
        end
        else if ((&rnd_top) || !(|rnd_top))
        begin
            y_next   = rnd[SAMPLE_BITS-1:0];
            sat_next = 1'b0;
        end
        else if (rnd[ROUND_BITS-1])
        begin
            y_next   = Y_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            y_next   = Y_MAX;
            sat_next = 1'b1;
        end
    end

    // Stage 4 inputs: feedback products on the output sample
    assign pa1_next = a1_reg * y3_reg;
    assign pa2_next = a2_reg * y3_reg;

    // Write-back: new delay pair
    assign z1_sum = ACC_BITS'(pb1_4_reg) - ACC_BITS'(pa1_4_reg) + ACC_BITS'(z2_4_reg);
    assign z2_sum = ACC_BITS'(pb2_4_reg) - ACC_BITS'(pa2_4_reg);
    assign wr_pair.delay_one = sat_state(z1_sum);
    assign wr_pair.delay_two = sat_state(z2_sum);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= accept;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (free5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage payload registers
    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            f1_reg    <= filt_in;
            ch1_reg   <= sample_data.channel;
            last1_reg <= sample_data.last_in_block;
            x1_reg    <= sample_data.sample_in;
            pb0_1_reg <= pb0_next;
            pb1_1_reg <= pb1_next;
            pb2_1_reg <= pb2_next;
        end
        if (free2)
        begin
            f2_reg    <= f1_reg;
            ch2_reg   <= ch1_reg;
            last2_reg <= last1_reg;
            x2_reg    <= x1_reg;
            acc2_reg  <= acc_next;
            pb1_2_reg <= pb1_1_reg;
            pb2_2_reg <= pb2_1_reg;
            z2_2_reg  <= rd_pair.delay_two;
        end
        if (free3)
        begin
            f3_reg    <= f2_reg;
            ch3_reg   <= ch2_reg;
            last3_reg <= last2_reg;
            y3_reg    <= y_next;
            sat3_reg  <= sat_next;
            pb1_3_reg <= pb1_2_reg;
            pb2_3_reg <= pb2_2_reg;
            z2_3_reg  <= z2_2_reg;
        end
        if (free4)
        begin
            f4_reg    <= f3_reg;
            ch4_reg   <= ch3_reg;
            last4_reg <= last3_reg;
            y4_reg    <= y3_reg;
            sat4_reg  <= sat3_reg;
            pa1_4_reg <= pa1_next;
            pa2_4_reg <= pa2_next;
            pb1_4_reg <= pb1_3_reg;
            pb2_4_reg <= pb2_3_reg;
            z2_4_reg  <= z2_3_reg;
        end
        if (free5)
        begin
            result_reg.channel_out <= ch4_reg;
            result_reg.sample_out  <= y4_reg;
            result_reg.saturated   <= sat4_reg;
            result_reg.last_out    <= last4_reg;
        end
    end

    assign result_valid = v5_reg;
    assign result_data  = result_reg;

    // No pipeline write-back while the clear sweep runs
    ap_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !ram_busy)
        else $error("state write-back during clear sweep");

    // Interlock keeps one filtered word per channel in stages one to four
    ap_one_per_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && f1_reg) |->
            !((v2_reg && f2_reg && ch2_reg == ch1_reg) ||
              (v3_reg && f3_reg && ch3_reg == ch1_reg) ||
              (v4_reg && f4_reg && ch4_reg == ch1_reg)))
        else $error("two filtered words of one channel in flight");

    // A clipped result sits at one of the range limits
    ap_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.saturated) |->
            (result_data.sample_out == Y_MAX || result_data.sample_out == Y_MIN))
        else $error("saturated flag without a clipped sample");

    // A word leaving stage four lands in the output register
    ap_stage4_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && free5) |=> result_valid)
        else $error("word lost between stage four and output");

endmodule

[src/mbhp_state_ram.sv]
module mbhp_state_ram
    import mbhp_pkg::*;
#(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output state_pair_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  state_pair_t       wr_data,
    output logic              busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    state_pair_t       mem [DEPTH];
    state_pair_t       rd_data_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              we_mux;
    logic [ADDR_W-1:0] waddr_mux;
    state_pair_t       wdata_mux;

    // Clear sweep after reset, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Sweep owns the write port while busy
    always_comb
    begin
        if (busy_reg)
        begin
            we_mux    = 1'b1;
            waddr_mux = clr_addr_reg;
            wdata_mux = '0;
        end
        else
        begin
            we_mux    = wr_en;
            waddr_mux = wr_addr;
            wdata_mux = wr_data;
        end
    end

    // Storage: one write port, one registered read port (read-before-write)
    always_ff @(posedge clk)
    begin
        if (we_mux)
        begin
            mem[waddr_mux] <= wdata_mux;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

[sim/tb.sv]
module tb;

    import mbhp_pkg::*;

    localparam int NCH = 512;

    // Fixed-point limits used by the predictor
    localparam longint STATE_HI = (longint'(1) <<< (STATE_BITS - 1)) - 1;
    localparam longint STATE_LO = -STATE_HI - 1;
    localparam longint OUT_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_LO   = -OUT_HI - 1;
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_BITS - 1);

    // Coefficient corner values
    localparam logic [COEFF_BITS-1:0] C_MAX  = 32'h7FFF_FFFF;
    localparam logic [COEFF_BITS-1:0] C_MIN  = 32'h8000_0000;
    localparam logic [COEFF_BITS-1:0] C_HALF = 32'h0800_0000;

    typedef enum logic {ROW_COEF, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [COEFF_BITS-1:0]   val;
        sample_t                 word;
        bit                      typed;
        result_t                 want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    cfg_write    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    logic [COEFF_BITS-1:0]   cfg_data     = '0;
    logic                    sample_valid = 1'b0;
    logic                    sample_ready;
    sample_t                 sample_data  = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    result_t                 result_data;

    // Predictor copy of coefficients and per-channel delay words
    longint cb0 = longint'(B0_RESET);
    longint cb1 = 0;
    longint cb2 = 0;
    longint ca1 = 0;
    longint ca2 = 0;
    longint z1_mem [NCH];
    longint z2_mem [NCH];

    result_t   pending_results [$];
    plan_row_t plan [$];

    int errors      = 0;
    int sender_pct  = 0;
    int stall_pct   = 0;
    bit pressure_go = 1'b0;

    multichannel_biquad_highpass #(.NUM_CHANNELS(NCH)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NCH; i++)
        begin
            z1_mem[i] = 0;
            z2_mem[i] = 0;
        end
    end

    function automatic longint clamp48(input longint v);
        if (v > STATE_HI)
            return STATE_HI;
        if (v < STATE_LO)
            return STATE_LO;
        return v;
    endfunction

    // One biquad update; electrode words touch the channel's delay pair
    function automatic result_t filter_word(input sample_t w);
        longint  x;
        longint  acc;
        longint  y;
        int      ch;
        result_t r;
        ch = int'(w.channel);
        x = longint'($signed(w.sample_in));
        r.channel_out = w.channel;
        r.sample_out = w.sample_in;
        r.saturated = 1'b0;
        r.last_out = w.last_in_block;
        if (w.is_electrode && ch < NCH)
        begin
            acc = clamp48(cb0 * x) + z1_mem[ch];
            y = (acc + HALF_LSB) >>> FRAC_BITS;
            if (y > OUT_HI)
            begin
                y = OUT_HI;
                r.saturated = 1'b1;
            end
            else if (y < OUT_LO)
            begin
                y = OUT_LO;
                r.saturated = 1'b1;
            end
            z1_mem[ch] = clamp48(clamp48(cb1 * x) - clamp48(ca1 * y) + z2_mem[ch]);
            z2_mem[ch] = clamp48(clamp48(cb2 * x) - clamp48(ca2 * y));
            r.sample_out = y[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic sample_t make_word(input logic [CH_BITS-1:0] ch,
                                          input logic signed [SAMPLE_BITS-1:0] x,
                                          input logic el, input logic last);
        sample_t w;
        w.channel = ch;
        w.sample_in = x;
        w.is_electrode = el;
        w.last_in_block = last;
        return w;
    endfunction

    // Directed table rows
    function automatic void row_coef(input logic [CFG_IDX_BITS-1:0] idx,
                                     input logic [COEFF_BITS-1:0] val);
        plan_row_t r;
        r.kind = ROW_COEF;
        r.idx = idx;
        r.val = val;
        r.word = '0;
        r.typed = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void row_word(input logic [CH_BITS-1:0] ch,
                                     input logic signed [SAMPLE_BITS-1:0] x,
                                     input logic el, input logic last);
        plan_row_t r;
        r.kind = ROW_WORD;
        r.idx = '0;
        r.val = '0;
        r.word = make_word(ch, x, el, last);
        r.typed = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void row_known(input logic [CH_BITS-1:0] ch,
                                      input logic signed [SAMPLE_BITS-1:0] x,
                                      input logic el, input logic last,
                                      input logic signed [SAMPLE_BITS-1:0] y,
                                      input logic sat);
        plan_row_t r;
        r.kind = ROW_WORD;
        r.idx = '0;
        r.val = '0;
        r.word = make_word(ch, x, el, last);
        r.typed = 1'b1;
        r.want.channel_out = ch;
        r.want.sample_out = y;
        r.want.saturated = sat;
        r.want.last_out = last;
        plan.push_back(r);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic [31:0] rnd;
        case ($urandom_range(0, 7))
            0: rnd = 32'h0000_7FFF;
            1: rnd = 32'h0000_8000;
            2, 3, 4: rnd = $urandom;
            default: rnd = $urandom_range(0, 1000) - 500;
        endcase
        return rnd[SAMPLE_BITS-1:0];
    endfunction

    // Register write; predictor coefficients follow at the same edge
    task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [COEFF_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_B0: cb0 = longint'($signed(val));
            CFG_B1: cb1 = longint'($signed(val));
            CFG_B2: cb2 = longint'($signed(val));
            CFG_A1: ca1 = longint'($signed(val));
            CFG_A2: ca2 = longint'($signed(val));
            default: ;
        endcase
    endtask

    // Drop valid and wait until every result word is back
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Offer one word, hold it until accepted, then queue its expected result
    task automatic offer(input sample_t w, input bit typed, input result_t want);
        result_t pred;
        if (cfg_write)
            cfg_write <= 1'b0;
        while ($urandom_range(0, 99) < sender_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data <= w;
        do
            @(posedge clk);
        while (!sample_ready);
        pred = filter_word(w);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic load_set(input int which);
        logic [31:0] rnd;
        case (which)
            0, 7:
            begin
                // Gentle high-pass, poles near the unit circle
                write_coef(CFG_B0, 32'sd263066747);
                write_coef(CFG_B1, -32'sd526133494);
                write_coef(CFG_B2, 32'sd263066747);
                write_coef(CFG_A1, -32'sd526000000);
                write_coef(CFG_A2, 32'sd257800000);
            end
            1:
            begin
                write_coef(CFG_B0, C_MAX);
                write_coef(CFG_B1, C_MAX);
                write_coef(CFG_B2, C_MAX);
                write_coef(CFG_A1, C_MAX);
                write_coef(CFG_A2, C_MAX);
            end
            2:
            begin
                write_coef(CFG_B0, C_MIN);
                write_coef(CFG_B1, C_MIN);
                write_coef(CFG_B2, C_MIN);
                write_coef(CFG_A1, C_MIN);
                write_coef(CFG_A2, C_MIN);
            end
            3:
            begin
                write_coef(CFG_B0, $urandom);
                write_coef(CFG_B1, $urandom);
                write_coef(CFG_B2, $urandom);
                write_coef(CFG_A1, $urandom);
                write_coef(CFG_A2, $urandom);
            end
            4:
            begin
                write_coef(CFG_B0, C_MAX);
                write_coef(CFG_B1, C_MIN);
                write_coef(CFG_B2, C_MAX);
                write_coef(CFG_A1, C_MAX);
                write_coef(CFG_A2, C_MIN);
            end
            5:
            begin
                // Random values within +/-1.0
                for (int i = CFG_B0; i <= CFG_A2; i++)
                begin
                    rnd = $urandom;
                    write_coef(CFG_IDX_BITS'(i), {{3{rnd[31]}}, rnd[31:3]});
                end
            end
            default:
            begin
                write_coef(CFG_B0, B0_RESET);
                write_coef(CFG_B1, '0);
                write_coef(CFG_B2, '0);
                write_coef(CFG_A1, '0);
                write_coef(CFG_A2, '0);
            end
        endcase
    endtask

    // Mostly channel-ordered blocks, with some raw noise and back-to-back repeats
    task automatic run_stream(input int n);
        int                 sent;
        int                 len;
        logic [CH_BITS-1:0] base;
        logic [CH_BITS-1:0] prev_ch;
        logic [31:0]        rnd;
        sample_t            w;
        sent = 0;
        prev_ch = '0;
        while (sent < n)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                base = CH_BITS'($urandom_range(0, NCH - 1));
                len = $urandom_range(1, 16);
                for (int k = 0; k < len && sent < n; k++)
                begin
                    w.channel = CH_BITS'(base + k);
                    w.sample_in = pick_sample();
                    w.is_electrode = ($urandom_range(0, 9) != 0);
                    w.last_in_block = (k == len - 1);
                    offer(w, 1'b0, '0);
                    prev_ch = w.channel;
                    sent++;
                end
            end
            else
            begin
                rnd = $urandom;
                w.channel = rnd[8:0];
                w.sample_in = rnd[24:9];
                w.is_electrode = rnd[25];
                w.last_in_block = rnd[26];
                if ($urandom_range(0, 1) != 0)
                    w.channel = prev_ch;
                offer(w, 1'b0, '0);
                prev_ch = w.channel;
                sent++;
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off to back the pipe up
    initial
    begin : receiver
        bit pressure_done;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_go && !pressure_done)
            begin
                pressure_done = 1'b1;
                for (int hold = 0; hold < 120; hold++)
                begin
                    result_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: channel_out %0d sample_out %0d",
                       result_data.channel_out, $signed(result_data.sample_out));
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_data.channel_out !== want.channel_out)
                begin
                    $error("channel_out: expected %0d, got %0d",
                           want.channel_out, result_data.channel_out);
                    errors++;
                end
                if (result_data.sample_out !== want.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want.sample_out), $signed(result_data.sample_out));
                    errors++;
                end
                if (result_data.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, result_data.saturated);
                    errors++;
                end
                if (result_data.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0d, got %0d",
                           want.last_out, result_data.last_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        bit prev_coef;
        int n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients: unity gain, delay words stay zero
        row_known(9'd0,    16'sd0,      1'b1, 1'b0, 16'sd0,      1'b0);
        row_known(9'd511,  16'sd32767,  1'b1, 1'b1, 16'sd32767,  1'b0);
        row_known(9'd0,    -16'sd32768, 1'b1, 1'b0, -16'sd32768, 1'b0);
        row_known(9'd5,    -16'sd1,     1'b1, 1'b0, -16'sd1,     1'b0);
        // Pass-through leaves the sample alone
        row_known(9'd511,  16'sd12345,  1'b0, 1'b1, 16'sd12345,  1'b0);
        // Largest b0: clipping both ways, pass-through never flags
        row_coef(CFG_B0, C_MAX);
        row_known(9'd3,    16'sd32767,  1'b1, 1'b0, 16'sd32767,  1'b1);
        row_known(9'd3,    -16'sd32768, 1'b1, 1'b1, -16'sd32768, 1'b1);
        row_known(9'd3,    -16'sd32768, 1'b0, 1'b0, -16'sd32768, 1'b0);
        // Most negative b0 flips the sign before clipping
        row_coef(CFG_B0, C_MIN);
        row_known(9'd200,  16'sd32767,  1'b1, 1'b0, -16'sd32768, 1'b1);
        row_known(9'd200,  -16'sd32768, 1'b1, 1'b0, 16'sd32767,  1'b1);
        row_known(9'd200,  16'sd0,      1'b1, 1'b1, 16'sd0,      1'b0);
        // b0 = 0.5: halves round up
        row_coef(CFG_B0, C_HALF);
        row_known(9'd7,    16'sd1,      1'b1, 1'b0, 16'sd1,      1'b0);
        row_known(9'd7,    -16'sd1,     1'b1, 1'b0, 16'sd0,      1'b0);
        row_known(9'd7,    -16'sd3,     1'b1, 1'b0, -16'sd1,     1'b0);
        // Extreme feedback: state clamps, same channel back to back
        row_coef(CFG_B0, C_MAX);
        row_coef(CFG_B1, C_MAX);
        row_coef(CFG_B2, C_MIN);
        row_coef(CFG_A1, C_MIN);
        row_coef(CFG_A2, C_MAX);
        row_word(9'd9,     16'sd32767,  1'b1, 1'b0);
        row_word(9'd9,     -16'sd32768, 1'b1, 1'b0);
        row_word(9'd9,     16'sd32767,  1'b0, 1'b0);
        row_word(9'd9,     16'sd32767,  1'b1, 1'b0);
        row_word(9'd10,    -16'sd32768, 1'b1, 1'b0);
        row_word(9'd9,     16'sd0,      1'b1, 1'b1);
        // Realistic high-pass
        row_coef(CFG_B0, 32'sd263066747);
        row_coef(CFG_B1, -32'sd526133494);
        row_coef(CFG_B2, 32'sd263066747);
        row_coef(CFG_A1, -32'sd526000000);
        row_coef(CFG_A2, 32'sd257800000);
        row_word(9'd9,     16'sd1000,   1'b1, 1'b0);
        row_word(9'd10,    16'sd1000,   1'b1, 1'b0);
        row_word(9'd9,     -16'sd2000,  1'b1, 1'b0);
        row_word(9'd10,    16'sd0,      1'b1, 1'b1);

        prev_coef = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_COEF)
            begin
                if (!prev_coef)
                    settle();
                write_coef(plan[i].idx, plan[i].val);
            end
            else
            begin
                offer(plan[i].word, plan[i].typed, plan[i].want);
            end
            prev_coef = (plan[i].kind == ROW_COEF);
        end

        // Random phases: coefficient set and idling pattern change per phase
        for (int p = 0; p < 8; p++)
        begin
            settle();
            load_set(p);
            case (p % 4)
                0:
                begin
                    sender_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    sender_pct = 69;
                    stall_pct <= 0;
                end
                2:
                begin
                    sender_pct = 0;
                    stall_pct <= 69;
                end
                default:
                begin
                    sender_pct = 11;
                    stall_pct <= 11;
                end
            endcase
            if (p == 4)
                pressure_go <= 1'b1;
            run_stream(250);
        end

        sample_valid <= 1'b0;
        for (n = 0; n < 50000 && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            errors++;
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
